// ===== sv/byte_fifo_with_overflow_tally_defines.svh =====
// Assertion helpers used by bfot_tally.
`ifndef BYTE_FIFO_WITH_OVERFLOW_TALLY_DEFINES_SVH
`define BYTE_FIFO_WITH_OVERFLOW_TALLY_DEFINES_SVH

// Checked only while reset is released.
`define BFOT_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define BFOT_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/bfot_pkg.sv =====
package bfot_pkg;

    localparam int DATA_W  = 8;
    localparam int CAP_W   = 11;
    localparam int TALLY_W = 32;
    localparam int CAP_RESET = 16;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_STATUS = 2'd3
    } opcode_t;

    // Overflow tally control, one step per transfer.
    typedef struct packed {
        logic clear;
        logic push_ok;
        logic push_refused;
        logic cont;
    } tally_ctl_t;

    // Result word, read_data in the lowest bits.
    typedef struct packed {
        logic [6:0]         pad;
        logic [TALLY_W-1:0] overflow_count;
        logic               is_full;
        logic               is_empty;
        logic [CAP_W-1:0]   free_count;
        logic [CAP_W-1:0]   queued_count;
        logic [DATA_W-1:0]  back_byte;
        logic [DATA_W-1:0]  front_byte;
        logic               push_accepted;
        logic [DATA_W-1:0]  read_data;
    } result_t;

    localparam int OUT_TDATA_W = $bits(result_t);

endpackage

// ===== sv/bfot_tally.sv =====
`include "byte_fifo_with_overflow_tally_defines.svh"

module bfot_tally
    import bfot_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  tally_ctl_t         ctl,
    output logic [TALLY_W-1:0] total_next
);

    logic [TALLY_W-1:0] total_reg;
    logic               flag_reg;
    logic               flag_next;

    always_comb begin
        total_next = total_reg;
        flag_next  = flag_reg;
        if (ctl.clear) begin
            total_next = '0;
            flag_next  = 1'b0;
        end else if (ctl.push_refused) begin
            // one event per burst, however many bytes it loses
            if (!(ctl.cont && flag_reg)) begin
                if (total_reg != {TALLY_W{1'b1}}) begin
                    total_next = total_reg + 1'b1;
                end
                flag_next = 1'b1;
            end
        end else if (ctl.push_ok && !ctl.cont) begin
            flag_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            flag_reg  <= 1'b0;
        end else begin
            total_reg <= total_next;
            flag_reg  <= flag_next;
        end
    end

    `BFOT_ASSERT(a_tally_sat, aclk, aresetn, (total_reg == {TALLY_W{1'b1}} && !ctl.clear) |=> (total_reg == {TALLY_W{1'b1}}), "tally left saturation")
    `BFOT_ASSERT(a_tally_clear, aclk, aresetn, ctl.clear |=> (total_reg == '0 && !flag_reg), "clear did not zero tally")
    `BFOT_ASSERT(a_tally_step, aclk, aresetn, !ctl.clear |=> (total_reg == $past(total_reg) || total_reg == TALLY_W'($past(total_reg) + 1'b1)), "tally moved by more than one")
    `BFOT_ASSERT(a_tally_burst, aclk, aresetn, (ctl.push_refused && ctl.cont && flag_reg && !ctl.clear) |=> $stable(total_reg), "burst counted twice")

endmodule

// ===== sv/byte_fifo_with_overflow_tally.sv =====
// Channel  | Dir | Signals                      | Contents
// s_       | in  | s_tvalid s_tready s_tdata    | tdata: data_in
//          |     | s_tuser                      | tuser: opcode, burst_continue
// m_       | out | m_tvalid m_tready m_tdata    | tdata: result_t word
// cfg_     | in  | cfg_valid cfg_ready cfg_data | capacity
//
// Push, clear and status transfers can follow back to back.
// Pop that leaves bytes queued: input stalls while the new front byte is
// fetched from the read port of the byte store; the result follows that fetch.
// Reset: synchronous, active low; capacity 16, queue empty, tally zero.
// Input stalls while the result register is full and not taken.
// A capacity write waits out a pending store read; input stalls while cfg_valid is high.
module byte_fifo_with_overflow_tally
    import bfot_pkg::*;
#(
    parameter int MAX_DEPTH = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_in
    input  logic [2:0]             s_tuser,   // [1:0] opcode, [2] burst_continue
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] read_data, [8] push_accepted, [16:9] front_byte, [24:17] back_byte,
    // [35:25] queued_count, [46:36] free_count, [47] is_empty, [48] is_full,
    // [80:49] overflow_count, [87:81] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CAP_W-1:0]       cfg_data
);

    localparam int AW = $clog2(MAX_DEPTH);

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
        return (idx == AW'(MAX_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    logic [DATA_W-1:0] byte_store_mem [MAX_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [CAP_W-1:0]  held_reg, held_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [DATA_W-1:0] front_reg, front_next;
    logic [DATA_W-1:0] last_reg, last_next;
    logic              fetch_reg, fetch_next;
    logic              m_tvalid_reg, m_tvalid_next;
    result_t           res_reg, res_next;

    logic               in_xfer;
    logic               cfg_xfer;
    logic               wr_en;
    logic               rd_en;
    opcode_t            op;
    logic               cont;
    tally_ctl_t         tally_ctl;
    logic [TALLY_W-1:0] tally_next;

    assign cfg_ready = !fetch_reg;
    assign s_tready  = !fetch_reg && !cfg_valid && (!m_tvalid_reg || m_tready);
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign op        = opcode_t'(s_tuser[1:0]);
    assign cont      = s_tuser[2];
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = res_reg;

    bfot_tally u_tally (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (tally_ctl),
        .total_next (tally_next)
    );

    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        held_next     = held_reg;
        cap_next      = cap_reg;
        front_next    = front_reg;
        last_next     = last_reg;
        fetch_next    = 1'b0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        res_next      = res_reg;
        tally_ctl     = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        if (cfg_xfer) begin
            cap_next = (32'(cfg_data) > 32'(MAX_DEPTH)) ? CAP_W'(MAX_DEPTH) : cfg_data;
            head_next = '0;
            tail_next = '0;
            held_next = '0;
            tally_ctl.clear = 1'b1;
        end else if (fetch_reg) begin
            // new front byte arrives from the store read
            front_next          = rd_data_reg;
            res_next.front_byte = rd_data_reg;
            m_tvalid_next       = 1'b1;
        end else if (in_xfer) begin
            res_next.read_data     = '0;
            res_next.push_accepted = 1'b0;
            tally_ctl.cont         = cont;
            case (op)
                OP_PUSH: begin
                    if (held_reg < cap_reg) begin
                        wr_en     = 1'b1;
                        tail_next = wrap_inc(tail_reg);
                        held_next = held_reg + 1'b1;
                        last_next = s_tdata;
                        if (held_reg == '0) begin
                            front_next = s_tdata;
                        end
                        res_next.push_accepted = 1'b1;
                        tally_ctl.push_ok      = 1'b1;
                    end else begin
                        tally_ctl.push_refused = 1'b1;
                    end
                end
                OP_POP: begin
                    if (held_reg != '0) begin
                        res_next.read_data = front_reg;
                        head_next          = wrap_inc(head_reg);
                        held_next          = held_reg - 1'b1;
                        if (held_reg != CAP_W'(1)) begin
                            rd_en      = 1'b1;
                            fetch_next = 1'b1;
                        end
                    end
                end
                OP_CLEAR: begin
                    head_next       = '0;
                    tail_next       = '0;
                    held_next       = '0;
                    tally_ctl.clear = 1'b1;
                end
                OP_STATUS: begin
                end
                default: begin
                end
            endcase
            res_next.pad            = '0;
            res_next.front_byte     = (held_next == '0) ? '0 : front_next;
            res_next.back_byte      = (held_next == '0) ? '0 : last_next;
            res_next.queued_count   = held_next;
            res_next.free_count     = (cap_reg >= held_next) ? cap_reg - held_next : '0;
            res_next.is_empty       = (held_next == '0);
            res_next.is_full        = (held_next >= cap_reg);
            res_next.overflow_count = tally_next;
            m_tvalid_next           = !fetch_next;
        end
    end

    // byte store: one write port at the tail, one read port at the next head
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            byte_store_mem[tail_reg] <= s_tdata;
        end
        if (rd_en) begin
            rd_data_reg <= byte_store_mem[head_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            held_reg     <= '0;
            cap_reg      <= CAP_W'(CAP_RESET);
            fetch_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            held_reg     <= held_next;
            cap_reg      <= cap_next;
            fetch_reg    <= fetch_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        front_reg <= front_next;
        last_reg  <= last_next;
        res_reg   <= res_next;
    end

endmodule
